// ----- rtl/bia_pkg.sv -----
// shared types, constants and bit-search helpers for the bitmap identifier allocator
// no dependencies; imported by bia_store and the allocator unit
`default_nettype none

package bia_pkg;

    localparam int WORD_BITS  = 64;
    localparam int NUM_WORDS  = 16;

    localparam int OP_W       = 2;
    localparam int ID_W       = 10;
    localparam int ST_W       = 2;
    localparam int HW_W       = 11;

    localparam int ID_LIMIT   = 1 << ID_W;
    localparam int TOTAL_BITS = WORD_BITS * NUM_WORDS;
    localparam int ID_SPACE   = (TOTAL_BITS < ID_LIMIT) ? TOTAL_BITS : ID_LIMIT;

    localparam int WADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);
    // wide enough for any bit position plus one
    localparam int POS_W      = $clog2(TOTAL_BITS) + 1;

    localparam int IN_DATA_W  = ((OP_W + ID_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ID_W + ST_W + HW_W + 7) / 8) * 8;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [WADDR_W-1:0]   t_waddr;
    typedef logic [BIT_W-1:0]     t_bit;
    typedef logic [POS_W-1:0]     t_pos;
    typedef logic [ID_W-1:0]      t_id;
    typedef logic [HW_W-1:0]      t_hw;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_CLAIM   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_BUSY      = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ALLOC,
        S_REL_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic   en;
        t_waddr addr;
        t_word  data;
    } t_wr_req;

    // position of the lowest clear bit; only meaningful when one exists
    function automatic t_bit find_low_zero(input t_word w);
        t_bit pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = t_bit'(i);
            end
        end
        return pos;
    endfunction

    // position of the highest set bit; only meaningful when one exists
    function automatic t_bit find_high_one(input t_word w);
        t_bit pos;
        pos = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (w[i]) begin
                pos = t_bit'(i);
            end
        end
        return pos;
    endfunction

    // absolute identifier of a bit within a word
    function automatic t_pos bit_index(input t_waddr widx, input t_bit b);
        return t_pos'(widx) * t_pos'(WORD_BITS) + t_pos'(b);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bia_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module bia_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/bia_store.sv -----
// usage bitmap storage: word ram plus per-word valid bits so reset clears it at once
// depends on bia_pkg and bia_ram
`default_nettype none

module bia_store (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bia_pkg::t_waddr  i_rd_addr,
    output bia_pkg::t_word        o_rd_word,
    input  wire bia_pkg::t_wr_req i_wr
);
    import bia_pkg::*;

    logic [NUM_WORDS-1:0] r_valid;
    logic                 r_rd_valid;
    t_word                ram_q;

    bia_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr.en),
        .i_wr_addr (i_wr.addr),
        .i_wr_data (i_wr.data),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_q)
    );

    // a word never written since reset reads as all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_valid[i_rd_addr];
    end

    assign o_rd_word = ram_q & {WORD_BITS{r_rd_valid}};

endmodule

`default_nettype wire

// ----- rtl/bitmap_id_allocator_high_water_unit.sv -----
// Identifier allocator over a 16 x 64-bit usage bitmap held in a one-port-read ram, with a
// high-water mark (one above the highest identifier in use). One transaction in gives one
// transaction out. The bitmap is read one word per cycle: claim and release check the
// identifier's own word and op 3 reads none, allocate scans upward from word 0 to the first
// word with a free bit, and release, when the top identifier is freed and its own word holds
// nothing lower, then scans the lower words downward to find the new high-water mark.
// The block works on one transaction at a time; a finished result waits in the output
// register while the next transaction is accepted. No clearing pass follows reset.
// depends on bia_pkg and bia_store
`default_nettype none

module bitmap_id_allocator_high_water_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // op [1:0], id [11:2], zero padding above
    input  wire logic [bia_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // id_out [9:0], status [11:10], high_water [22:12], zero padding above
    output logic      [bia_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import bia_pkg::*;

    t_state  r_state,   n_state;
    t_op     r_op,      n_op;
    t_id     r_id,      n_id;
    t_waddr  r_widx,    n_widx;
    t_bit    r_bit,     n_bit;
    t_hw     r_hwm,     n_hwm;
    t_id     r_res_id,  n_res_id;
    t_status r_res_st,  n_res_st;
    logic    r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    t_waddr  rd_addr;
    t_word   rd_word;
    t_wr_req wr;

    t_op     in_op;
    t_id     in_id;
    logic    in_id_ok;
    t_waddr  in_word;
    t_bit    in_bit;

    t_word   bit_mask;
    t_word   cleared;
    t_word   lower;
    t_bit    zero_pos;
    t_bit    one_pos;
    t_pos    found;
    t_pos    found_p1;

    bia_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_word (rd_word),
        .i_wr      (wr)
    );

    assign in_op    = t_op'(s_axis_tdata[OP_W-1:0]);
    assign in_id    = s_axis_tdata[OP_W+ID_W-1:OP_W];
    assign in_id_ok = {1'b0, in_id} < HW_W'(ID_SPACE);
    assign in_word  = WADDR_W'(in_id / ID_W'(WORD_BITS));
    assign in_bit   = BIT_W'(in_id % ID_W'(WORD_BITS));

    assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << r_bit;
    assign cleared  = rd_word & ~bit_mask;
    assign lower    = cleared & (bit_mask - {{(WORD_BITS-1){1'b0}}, 1'b1});
    assign zero_pos = find_low_zero(rd_word);

    // highest set bit of whichever word the current state searches
    always_comb begin
        if (r_state == S_REL_SCAN) begin
            one_pos = find_high_one(rd_word);
        end else begin
            one_pos = find_high_one(lower);
        end
    end

    always_comb begin
        if (r_state == S_ALLOC) begin
            found = bit_index(r_widx, zero_pos);
        end else begin
            found = bit_index(r_widx, one_pos);
        end
    end

    assign found_p1 = found + t_pos'(1);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_id        = r_id;
        n_widx      = r_widx;
        n_bit       = r_bit;
        n_hwm       = r_hwm;
        n_res_id    = r_res_id;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid & ~m_axis_tready;
        n_out_data  = r_out_data;
        rd_addr     = r_widx;
        wr.en       = 1'b0;
        wr.addr     = r_widx;
        wr.data     = rd_word | bit_mask;
        s_axis_tready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_op     = in_op;
                    n_id     = in_id;
                    n_widx   = in_word;
                    n_bit    = in_bit;
                    n_res_id = in_id;
                    n_res_st = ST_OK;
                    rd_addr  = in_word;
                    unique case (in_op)
                        OP_ALLOC: begin
                            n_widx  = '0;
                            rd_addr = '0;
                            n_state = S_ALLOC;
                        end
                        OP_CLAIM: begin
                            if (in_id_ok) begin
                                n_state = S_CHECK;
                            end else begin
                                n_res_st = ST_BUSY;
                                n_state  = S_DONE;
                            end
                        end
                        OP_RELEASE: begin
                            if (in_id_ok) begin
                                n_state = S_CHECK;
                            end else begin
                                n_res_st = ST_NOT_ALLOC;
                                n_state  = S_DONE;
                            end
                        end
                        OP_NOP: begin
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_CHECK: begin
                n_state = S_DONE;
                if (r_op == OP_CLAIM) begin
                    if ((rd_word & bit_mask) != '0) begin
                        n_res_st = ST_BUSY;
                    end else begin
                        wr.en   = 1'b1;
                        wr.data = rd_word | bit_mask;
                        if ({1'b0, r_id} >= r_hwm) begin
                            n_hwm = t_hw'({1'b0, r_id}) + t_hw'(1);
                        end
                    end
                end else if ((rd_word & bit_mask) == '0) begin
                    n_res_st = ST_NOT_ALLOC;
                end else begin
                    wr.en   = 1'b1;
                    wr.data = cleared;
                    // freeing the top identifier: look below it, own word first
                    if (r_hwm == t_hw'({1'b0, r_id}) + t_hw'(1)) begin
                        if (lower != '0) begin
                            n_hwm = t_hw'(found_p1);
                        end else if (r_widx == '0) begin
                            n_hwm = '0;
                        end else begin
                            n_widx  = r_widx - t_waddr'(1);
                            rd_addr = r_widx - t_waddr'(1);
                            n_state = S_REL_SCAN;
                        end
                    end
                end
            end

            S_ALLOC: begin
                if (~rd_word != '0) begin
                    n_state = S_DONE;
                    if (found < t_pos'(ID_SPACE)) begin
                        wr.en    = 1'b1;
                        wr.data  = rd_word | ({{(WORD_BITS-1){1'b0}}, 1'b1} << zero_pos);
                        n_res_id = t_id'(found);
                        n_res_st = ST_OK;
                        if (t_hw'(found) >= r_hwm) begin
                            n_hwm = t_hw'(found_p1);
                        end
                    end else begin
                        n_res_id = '0;
                        n_res_st = ST_FULL;
                    end
                end else if (r_widx == t_waddr'(NUM_WORDS - 1)) begin
                    n_state  = S_DONE;
                    n_res_id = '0;
                    n_res_st = ST_FULL;
                end else begin
                    n_widx  = r_widx + t_waddr'(1);
                    rd_addr = r_widx + t_waddr'(1);
                end
            end

            S_REL_SCAN: begin
                if (rd_word != '0) begin
                    n_hwm   = t_hw'(found_p1);
                    n_state = S_DONE;
                end else if (r_widx == '0) begin
                    n_hwm   = '0;
                    n_state = S_DONE;
                end else begin
                    n_widx  = r_widx - t_waddr'(1);
                    rd_addr = r_widx - t_waddr'(1);
                end
            end

            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_DATA_W'({r_hwm, r_res_st, r_res_id});
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hwm       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hwm       <= n_hwm;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_id       <= n_id;
        r_widx     <= n_widx;
        r_bit      <= n_bit;
        r_res_id   <= n_res_id;
        r_res_st   <= n_res_st;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
